// ===== rtl/pbc_pkg.sv =====
// ----------------------------------------------------------------------------
// pbc_pkg
// Shared types, constants and the CRC32C byte step for the page blob checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pbc_pkg;

  localparam int unsigned HEADER_BYTES = 13;
  localparam int unsigned CNT_W        = 33;
  localparam int unsigned PAGE_W       = 21;
  localparam int unsigned CFG_W        = 21;
  localparam int unsigned CFG_IDX_W    = 2;

  localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  // header byte offsets
  localparam logic [CNT_W-1:0] OFS_ALGO   = CNT_W'(0);
  localparam logic [CNT_W-1:0] OFS_RAW    = CNT_W'(1);
  localparam logic [CNT_W-1:0] OFS_STORED = CNT_W'(5);
  localparam logic [CNT_W-1:0] OFS_CRC    = CNT_W'(9);
  localparam logic [CNT_W-1:0] OFS_BODY   = CNT_W'(HEADER_BYTES);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SIZE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_UNCOMP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_LZ4     = 2'd2;

  // status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_SHORT       = 3'd1;
  localparam logic [2:0] ST_RAW_MISMATCH = 3'd2;
  localparam logic [2:0] ST_OVERRUN     = 3'd3;
  localparam logic [2:0] ST_CRC         = 3'd4;
  localparam logic [2:0] ST_RAW_SIZE    = 3'd5;
  localparam logic [2:0] ST_LZ4         = 3'd6;
  localparam logic [2:0] ST_UNKNOWN     = 3'd7;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       payload_byte;
    logic             payload_valid;
    logic             done_res;
    logic [2:0]       status;
    logic [7:0]       algo_seen;
    logic [31:0]      raw_length;
    logic [CNT_W-1:0] logical_length;
  } out_item_t;

  // settings held in the configuration registers
  typedef struct packed {
    logic [PAGE_W-1:0] page_size;
    logic [7:0]        code_uncomp;
    logic [7:0]        code_lz4;
  } cfg_t;

  // blob context after folding in the current byte
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [7:0]       algo;
    logic [31:0]      raw_len;
    logic [31:0]      region_len;
    logic [31:0]      exp_crc;
    logic [31:0]      crc;
    logic             in_body;
  } blob_ctx_t;

  // reflected CRC32C, one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/pbc_frame.sv =====
// ----------------------------------------------------------------------------
// pbc_frame
// Byte counter, header capture and running CRC over the stored region.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pbc_frame import pbc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      accept,
  input  in_item_t  item,
  output blob_ctx_t ctx
);

  logic [CNT_W-1:0] count_r;
  logic [7:0]       algo_r;
  logic [31:0]      raw_len_r;
  logic [31:0]      region_len_r;
  logic [31:0]      exp_crc_r;
  logic [31:0]      crc_r;

  logic [1:0]       lane;
  logic [31:0]      lane_mask;
  logic [31:0]      lane_data;
  logic [CNT_W-1:0] body_ofs;

  always_comb begin
    // header words start at offsets 1, 5 and 9: lane is (pos - 1) mod 4
    lane      = count_r[1:0] - 2'd1;
    lane_mask = 32'hFF << {lane, 3'b000};
    lane_data = {24'd0, item.data_byte} << {lane, 3'b000};
    body_ofs  = count_r - OFS_BODY;

    ctx.count      = (count_r == COUNT_MAX) ? count_r : count_r + CNT_W'(1);
    ctx.algo       = algo_r;
    ctx.raw_len    = raw_len_r;
    ctx.region_len = region_len_r;
    ctx.exp_crc    = exp_crc_r;
    ctx.crc        = crc_r;
    ctx.in_body    = 1'b0;

    if (count_r == OFS_ALGO) begin
      ctx.algo = item.data_byte;
    end else if (count_r < OFS_STORED) begin
      ctx.raw_len = (raw_len_r & ~lane_mask) | lane_data;
    end else if (count_r < OFS_CRC) begin
      ctx.region_len = (region_len_r & ~lane_mask) | lane_data;
    end else if (count_r < OFS_BODY) begin
      ctx.exp_crc = (exp_crc_r & ~lane_mask) | lane_data;
    end else if (body_ofs < {1'b0, region_len_r}) begin
      ctx.in_body = 1'b1;
      ctx.crc     = crc_byte(crc_r, item.data_byte);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      algo_r       <= '0;
      raw_len_r    <= '0;
      region_len_r <= '0;
      exp_crc_r    <= '0;
      crc_r        <= CRC_INIT;
    end else if (accept) begin
      if (item.last_byte) begin
        count_r      <= '0;
        algo_r       <= '0;
        raw_len_r    <= '0;
        region_len_r <= '0;
        exp_crc_r    <= '0;
        crc_r        <= CRC_INIT;
      end else begin
        count_r      <= ctx.count;
        algo_r       <= ctx.algo;
        raw_len_r    <= ctx.raw_len;
        region_len_r <= ctx.region_len;
        exp_crc_r    <= ctx.exp_crc;
        crc_r        <= ctx.crc;
      end
    end
  end

endmodule

// ===== rtl/pbc_verdict.sv =====
// ----------------------------------------------------------------------------
// pbc_verdict
// Builds the result item: pass-through byte and end-of-blob status.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pbc_verdict import pbc_pkg::*; (
  input  cfg_t      cfg,
  input  in_item_t  item,
  input  blob_ctx_t ctx,
  output out_item_t res
);

  logic [CNT_W-1:0] logical;
  logic [2:0]       status;
  logic             short_blob;

  always_comb begin
    logical    = OFS_BODY + {1'b0, ctx.region_len};
    short_blob = ctx.count < OFS_BODY;

    if (short_blob) begin
      status = ST_SHORT;
    end else if (ctx.raw_len != {11'd0, cfg.page_size}) begin
      status = ST_RAW_MISMATCH;
    end else if (logical > ctx.count) begin
      status = ST_OVERRUN;
    end else if ((ctx.crc ^ CRC_INIT) != ctx.exp_crc) begin
      status = ST_CRC;
    end else if (ctx.algo == cfg.code_uncomp) begin
      status = (ctx.region_len != {11'd0, cfg.page_size}) ? ST_RAW_SIZE : ST_OK;
    end else if (ctx.algo == cfg.code_lz4) begin
      status = ST_LZ4;
    end else begin
      status = ST_UNKNOWN;
    end

    res.payload_byte   = ctx.in_body ? item.data_byte : 8'd0;
    res.payload_valid  = ctx.in_body;
    res.done_res       = item.last_byte;
    res.status         = ST_OK;
    res.algo_seen      = '0;
    res.raw_length     = '0;
    res.logical_length = '0;
    if (item.last_byte) begin
      res.status    = status;
      res.algo_seen = ctx.algo;
      if (!short_blob) begin
        res.raw_length     = ctx.raw_len;
        res.logical_length = logical;
      end
    end
  end

endmodule

// ===== rtl/page_blob_checker.sv =====
// ----------------------------------------------------------------------------
// page_blob_checker
// Length-prefixed page blob checker with CRC32C over the stored region.
// ----------------------------------------------------------------------------
// A byte's result is registered: the edge that accepts a byte loads its result into out_*.
// Throughput: one byte per cycle while in_stall is low; the header capture, byte-wide CRC32C step
//   and status compare all fit between the blob state and the result register.
// in_stall rises only while a result sits in the output register and the
//   downstream side stalls it.
// Reset (rst_n low, synchronous): blob state cleared, CRC set to all ones,
//   output register emptied, page_size=4096, code_uncompressed=0, code_lz4=1.
`timescale 1ns / 1ps

module page_blob_checker import pbc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // byte input
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  // result output
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  // configuration writes
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  cfg_t      cfg_r;
  logic      out_valid_r;
  out_item_t out_data_r;

  logic      in_accept;
  blob_ctx_t ctx;
  out_item_t res;

  // Output register doubles as the skid stage: a new transaction is taken
  // whenever the register is empty or is being drained this cycle.
  assign in_stall  = out_valid_r & out_stall;
  assign in_accept = in_valid & ~in_stall;

  // Configuration registers; indexes past the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.page_size   <= PAGE_W'(4096);
      cfg_r.code_uncomp <= 8'd0;
      cfg_r.code_lz4    <= 8'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PAGE_SIZE:   cfg_r.page_size   <= cfg_wdata[PAGE_W-1:0];
        CFG_CODE_UNCOMP: cfg_r.code_uncomp <= cfg_wdata[7:0];
        CFG_CODE_LZ4:    cfg_r.code_lz4    <= cfg_wdata[7:0];
        default:         ;
      endcase
    end
  end

  // Blob state: count, header fields, running CRC.
  pbc_frame u_frame (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (in_accept),
    .item   (in_data),
    .ctx    (ctx)
  );

  // Result formation, status priority on the last byte.
  pbc_verdict u_verdict (
    .cfg  (cfg_r),
    .item (in_data),
    .ctx  (ctx),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // payload: no reset needed
  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/pbc_checker.sv =====
// ----------------------------------------------------------------------------
// pbc_checker
// Port-level assertions for the page blob checker, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pbc_checker import pbc_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // mid-blob results carry no summary
  a_mid_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.done_res |->
      out_data.status == ST_OK && out_data.algo_seen == 8'd0 &&
      out_data.raw_length == 32'd0 && out_data.logical_length == '0)
    else $error("summary fields set before last byte");

  // bytes outside the stored region are zeroed
  a_gap_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.payload_valid |-> out_data.payload_byte == 8'd0)
    else $error("payload byte leaked outside stored region");

  // a short blob reports no lengths
  a_short_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.done_res && out_data.status == ST_SHORT |->
      out_data.raw_length == 32'd0 && out_data.logical_length == '0)
    else $error("lengths reported for short blob");

endmodule

bind page_blob_checker pbc_checker u_pbc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for page_blob_checker: streams page blobs byte by byte
// under changing register settings and flow-control pressure, and compares
// every result transaction field by field with a cycle-free predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import pbc_pkg::*;

  // index 3 decodes to no register; writes to it must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam logic [CNT_W-1:0]     HDR_LEN    = CNT_W'(HEADER_BYTES);
  localparam int PHASES          = 10;
  localparam int BYTES_PER_PHASE = 185;
  localparam int CYCLE_LIMIT     = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  page_blob_checker dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor state: register copies and the per-blob context.
  // Initial values match the reset state of the block.
  // --------------------------------------------------------------------------
  logic [PAGE_W-1:0] page_size_r = PAGE_W'(4096);
  logic [7:0]        code_plain  = 8'd0;
  logic [7:0]        code_lz4_r  = 8'd1;

  logic [CNT_W-1:0]  cur_pos     = '0;   // bytes seen in this blob, saturating
  logic [7:0]        cur_algo    = '0;
  logic [31:0]       cur_raw     = '0;
  logic [31:0]       cur_stored  = '0;
  logic [31:0]       cur_crc_hdr = '0;   // CRC word carried in the header
  logic [31:0]       cur_crc     = '1;   // running CRC over the stored region

  in_item_t  bytes_to_send[$];   // blob bytes not yet offered to the block
  out_item_t results_due[$];     // predicted results, oldest first
  logic      feed_busy = 1'b0;   // a transaction is on in_* and not taken yet
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        mismatches = 0;
  int        phase_bytes = 0;
  int        cycle_count = 0;

  // Reflected CRC32C, one data bit at a time (LSB first).
  function automatic logic [31:0] crc32c_step(input logic [31:0] crc, input logic [7:0] d);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb  = crc[0] ^ d[i];
      crc = crc >> 1;
      if (fb) crc = crc ^ CRC_POLY;
    end
    return crc;
  endfunction

  // Folds one accepted byte into the blob context and returns the result
  // the block must produce for it. On the last byte the status is resolved
  // in priority order and the context goes back to its reset state.
  function automatic out_item_t predict_blob_byte(input in_item_t it);
    out_item_t   r;
    logic [CNT_W-1:0] logical;
    int          lane;
    r    = '0;
    lane = int'(cur_pos[3:0]);
    if (cur_pos == '0) begin
      cur_algo = it.data_byte;
    end else if (cur_pos < CNT_W'(5)) begin
      cur_raw[8*(lane-1) +: 8] = it.data_byte;
    end else if (cur_pos < CNT_W'(9)) begin
      cur_stored[8*(lane-5) +: 8] = it.data_byte;
    end else if (cur_pos < HDR_LEN) begin
      cur_crc_hdr[8*(lane-9) +: 8] = it.data_byte;
    end else if (cur_pos - HDR_LEN < {1'b0, cur_stored}) begin
      r.payload_valid = 1'b1;
      r.payload_byte  = it.data_byte;
      cur_crc         = crc32c_step(cur_crc, it.data_byte);
    end
    if (cur_pos != '1) cur_pos = cur_pos + 1'b1;

    r.done_res = it.last_byte;
    if (it.last_byte) begin
      logical     = HDR_LEN + {1'b0, cur_stored};
      r.algo_seen = cur_algo;
      if (cur_pos < HDR_LEN) begin
        r.status = ST_SHORT;
      end else begin
        if (cur_raw != {11'd0, page_size_r})
          r.status = ST_RAW_MISMATCH;
        else if (logical > cur_pos)
          r.status = ST_OVERRUN;
        else if (~cur_crc != cur_crc_hdr)
          r.status = ST_CRC;
        else if (cur_algo == code_plain)   // plain wins when both codes match
          r.status = (cur_stored != {11'd0, page_size_r}) ? ST_RAW_SIZE : ST_OK;
        else if (cur_algo == code_lz4_r)
          r.status = ST_LZ4;
        else
          r.status = ST_UNKNOWN;
        r.raw_length     = cur_raw;
        r.logical_length = logical;
      end
      cur_pos     = '0;
      cur_algo    = '0;
      cur_raw     = '0;
      cur_stored  = '0;
      cur_crc_hdr = '0;
      cur_crc     = '1;
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: offers queued bytes at the falling edge, idles at random.
  // A transaction stays on in_* untouched until the monitor sees it taken.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n) begin
      if (!feed_busy) begin
        if (bytes_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data   <= bytes_to_send.pop_front();
          in_valid  <= 1'b1;
          feed_busy =  1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: at the rising edge, check a result transaction first, then
  // predict for an input transaction. A result never belongs to a byte taken
  // at the same edge, so this order cannot hide a spurious result.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        $error("result transaction with no byte pending");
        mismatches++;
      end else begin
        want = results_due.pop_front();
        check_field("payload_byte",   want.payload_byte,   out_data.payload_byte);
        check_field("payload_valid",  want.payload_valid,  out_data.payload_valid);
        check_field("done_res",       want.done_res,       out_data.done_res);
        check_field("status",         want.status,         out_data.status);
        check_field("algo_seen",      want.algo_seen,      out_data.algo_seen);
        check_field("raw_length",     want.raw_length,     out_data.raw_length);
        check_field("logical_length", want.logical_length, out_data.logical_length);
      end
    end
    if (rst_n && in_valid && !in_stall) begin
      results_due = {results_due, predict_blob_byte(in_data)};
      feed_busy = 1'b0;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL page_blob_checker");
      $finish;
    end
  end

  // Queue a byte string as one blob; the final byte carries the last flag.
  task automatic send_bytes(input logic [7:0] q[$]);
    in_item_t it;
    foreach (q[i]) begin
      it.data_byte = q[i];
      it.last_byte = (i == q.size() - 1);
      bytes_to_send = {bytes_to_send, it};
      phase_bytes++;
    end
  endtask

  // Build a blob: header, then body_n random bytes. The header CRC covers the
  // part of the body inside the stored region; bad_crc flips one bit of it.
  task automatic add_blob(input logic [7:0] algo, input logic [31:0] raw_len,
                          input logic [31:0] region_len, input int body_n,
                          input bit bad_crc);
    logic [7:0]  body[$];
    logic [7:0]  blob[$];
    logic [31:0] crc;
    crc = '1;
    for (int i = 0; i < body_n; i++) begin
      body = {body, 8'($urandom)};
      if (i < region_len) crc = crc32c_step(crc, body[i]);
    end
    crc = ~crc;
    if (bad_crc) crc = crc ^ (32'd1 << $urandom_range(31));
    blob = {blob, algo};
    for (int i = 0; i < 4; i++) blob = {blob, raw_len[8*i +: 8]};
    for (int i = 0; i < 4; i++) blob = {blob, region_len[8*i +: 8]};
    for (int i = 0; i < 4; i++) blob = {blob, crc[8*i +: 8]};
    foreach (body[i]) blob = {blob, body[i]};
    send_bytes(blob);
  endtask

  // Register write; the predictor copy follows at once since the block is idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_PAGE_SIZE:   page_size_r = val[PAGE_W-1:0];
      CFG_CODE_UNCOMP: code_plain  = val[7:0];
      CFG_CODE_LZ4:    code_lz4_r  = val[7:0];
      default: ;
    endcase
  endtask

  // Returns once every queued byte has been taken and every result checked.
  task automatic wait_drained();
    while (bytes_to_send.size() != 0 || feed_busy || results_due.size() != 0)
      @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus. Phase 0 runs at the reset settings and opens with a few
  // directed blobs; each later phase rewrites the registers and changes the
  // flow-control pattern. Random blobs are mostly well formed so that the
  // body and status logic get exercised; the rest are short blobs and noise.
  // --------------------------------------------------------------------------
  initial begin
    logic [7:0]  junk[$];
    logic [7:0]  algo;
    logic [31:0] raw_len;
    logic [31:0] region_len;
    int          body_n;
    int          pick;
    int          n;
    in_item_t    it;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        1: begin
          write_reg(CFG_PAGE_SIZE,   '0);
          write_reg(CFG_CODE_UNCOMP, {13'($urandom), 8'h00});
          write_reg(CFG_CODE_LZ4,    {13'($urandom), 8'hFF});
        end
        2: begin
          write_reg(CFG_PAGE_SIZE,   CFG_W'(1));
          write_reg(CFG_CODE_UNCOMP, {13'($urandom), 8'hFF});
          write_reg(CFG_CODE_LZ4,    {13'($urandom), 8'h00});
        end
        3: begin
          write_reg(CFG_PAGE_SIZE,   '1);
          write_reg(CFG_CODE_UNCOMP, CFG_W'($urandom));
          write_reg(CFG_CODE_LZ4,    CFG_W'($urandom));
        end
        4: begin
          // a page of 1048576 bytes, and both codes equal
          write_reg(CFG_PAGE_SIZE,   CFG_W'(1048576));
          write_reg(CFG_CODE_UNCOMP, {13'($urandom), 8'h5A});
          write_reg(CFG_CODE_LZ4,    {13'($urandom), 8'h5A});
        end
        6: begin
          write_reg(CFG_PAGE_SIZE,   CFG_W'(16));
          write_reg(CFG_CODE_UNCOMP, CFG_W'($urandom));
          write_reg(CFG_CODE_LZ4,    CFG_W'($urandom));
        end
        7: begin
          write_reg(CFG_PAGE_SIZE,   CFG_W'($urandom));
          write_reg(CFG_CODE_UNCOMP, CFG_W'($urandom));
          write_reg(CFG_CODE_LZ4,    CFG_W'($urandom));
        end
        9: begin
          write_reg(CFG_PAGE_SIZE,   CFG_W'(8));
          write_reg(CFG_CODE_UNCOMP, CFG_W'(1));
          write_reg(CFG_CODE_LZ4,    CFG_W'(0));
        end
        default: begin
          if (phase != 0) begin
            write_reg(CFG_PAGE_SIZE,   CFG_W'($urandom_range(0, 12)));
            write_reg(CFG_CODE_UNCOMP, CFG_W'($urandom));
            write_reg(CFG_CODE_LZ4,    CFG_W'($urandom));
          end
        end
      endcase
      if (phase != 0) write_reg(CFG_UNUSED, CFG_W'($urandom));

      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      phase_bytes = 0;

      if (phase == 0) begin
        // one-byte blob: short, algo_seen shows the lone byte
        junk = {8'hFF};
        send_bytes(junk);
        // header only, empty stored region, LZ4 code: unsupported
        add_blob(code_lz4_r, 32'd4096, 32'd0, 0, 1'b0);
        // one byte shy of a full header
        junk = {8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF,
                8'h00, 8'hFF};
        send_bytes(junk);
      end

      while (phase_bytes < BYTES_PER_PHASE) begin
        pick = $urandom_range(99);
        if (pick < 5) begin
          // truncated header
          junk = {};
          n = $urandom_range(1, 12);
          for (int i = 0; i < n; i++) junk = {junk, 8'($urandom)};
          send_bytes(junk);
        end else if (pick < 12) begin
          // noise with stray last flags
          n = $urandom_range(2, 20);
          for (int i = 0; i < n; i++) begin
            it.data_byte = 8'($urandom);
            it.last_byte = (i == n - 1) || ($urandom_range(7) == 0);
            bytes_to_send = {bytes_to_send, it};
            phase_bytes++;
          end
        end else begin
          pick = $urandom_range(99);
          algo = (pick < 50) ? code_plain : (pick < 75) ? code_lz4_r : 8'($urandom);

          pick = $urandom_range(99);
          if (pick < 88)      raw_len = {11'd0, page_size_r};
          else if (pick < 94) raw_len = {11'd0, page_size_r} ^ (32'd1 << $urandom_range(31));
          else                raw_len = $urandom;

          pick = $urandom_range(99);
          if (algo == code_plain && page_size_r <= 40 && pick < 50)
            region_len = {11'd0, page_size_r};
          else if (pick < 56) region_len = '1;
          else if (pick < 60) region_len = $urandom;
          else                region_len = $urandom_range(0, 12);

          pick = $urandom_range(99);
          if (region_len > 40)
            body_n = $urandom_range(0, 8);            // stored region overruns blob
          else if (pick < 8)
            body_n = (region_len == 0) ? 0 : $urandom_range(0, int'(region_len) - 1);
          else if (pick < 33)
            body_n = int'(region_len) + $urandom_range(1, 4);  // trailing bytes ignored
          else
            body_n = int'(region_len);

          add_blob(algo, raw_len, region_len, body_n, $urandom_range(99) < 10);
        end
      end
      wait_drained();
    end

    // let any stray result show up before the verdict
    repeat (8) @(posedge clk);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("PASS page_blob_checker");
    end else begin
      $display("FAIL page_blob_checker");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/pbc_pkg.sv
rtl/pbc_frame.sv
rtl/pbc_verdict.sv
rtl/page_blob_checker.sv
rtl/pbc_checker.sv
tb/tb_top.sv
